### hw/rtl/mscg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mscg_pkg
// Shared types and constants of the multi-stop color gradient block.
// ============================================================================
package mscg_pkg;

   localparam int unsigned POS_W   = 16;
   localparam int unsigned COLOR_W = 24;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned ACT_W   = 2;

   // alpha is Q16 with 1.0 included, so one extra bit
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned ALPHA_W   = FRAC_W + 1;
   localparam int unsigned DIV_STEPS = ALPHA_W;
   localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
   localparam int unsigned NUM_CHANS = 3;
   localparam int unsigned CH_W      = $clog2(NUM_CHANS);

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_ORDER = 2'd1,
      ST_FULL  = 2'd2,
      ST_FEW   = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic append;
      logic blank;
      logic few;
      logic scan_start;
      logic advance;
      logic take_rd;
      logic seg_start;
      logic div_step;
      logic blend_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       count_lt2;
      logic       hit;
      logic       idx_zero;
      logic       idx_last;
      logic       div_last;
      logic       blend_last;
      logic       out_busy;
   } stat_type;

endpackage

### hw/rtl/mscg_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mscg_req_if
// Request channel: action, position and stop color words.
// ============================================================================
interface mscg_req_if;
   logic                              valid;
   logic                              ready;
   logic [mscg_pkg::ACT_W-1:0]        action;
   logic signed [mscg_pkg::POS_W-1:0] position;
   logic [mscg_pkg::COLOR_W-1:0]      stop_color;

   modport source (output valid, output action, output position, output stop_color,
                   input ready);
   modport sink   (input valid, input action, input position, input stop_color,
                   output ready);
endinterface

### hw/rtl/mscg_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mscg_rsp_if
// Response channel: interpolated color and status words.
// ============================================================================
interface mscg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mscg_pkg::CHAN_W-1:0]   red;
   logic [mscg_pkg::CHAN_W-1:0]   green;
   logic [mscg_pkg::CHAN_W-1:0]   blue;
   logic [mscg_pkg::STAT_W-1:0]   status;

   modport source (output valid, output red, output green, output blue, output status,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input status,
                   output ready);
endinterface

### hw/rtl/mscg_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mscg_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module mscg_ram #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mscg_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mscg_ctrl
// Sequencer: decode, stop scan, alpha division, channel blend, result hand-off.
// ============================================================================
module mscg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mscg_pkg::stat_type stat,
   output mscg_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_DIVIDE,
      S_BLEND,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action)
               mscg_pkg::ACT_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.blank = 1'b1;
                  state_in  = S_FINISH;
               end
               mscg_pkg::ACT_APPEND: begin
                  cmd.append = 1'b1;
                  state_in   = S_FINISH;
               end
               mscg_pkg::ACT_LOOKUP: begin
                  if (stat.count_lt2) begin
                     cmd.few  = 1'b1;
                     state_in = S_FINISH;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  cmd.blank = 1'b1;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            priority if (stat.hit && stat.idx_zero) begin
               cmd.take_rd = 1'b1;
               state_in    = S_FINISH;
            end else if (stat.hit) begin
               cmd.seg_start = 1'b1;
               state_in      = S_DIVIDE;
            end else if (stat.idx_last) begin
               cmd.take_rd = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.blend_step = 1'b1;
            if (stat.blend_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/mscg_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// mscg_dp
// Datapath: stop table, segment registers, restoring divider, blender and
// the output register.
// ============================================================================
module mscg_dp #(
   parameter int unsigned TABLE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mscg_pkg::cmd_type                   cmd,
   output mscg_pkg::stat_type                  stat,
   input  logic [mscg_pkg::ACT_W-1:0]          req_action,
   input  logic signed [mscg_pkg::POS_W-1:0]   req_position,
   input  logic [mscg_pkg::COLOR_W-1:0]        req_stop_color,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [mscg_pkg::CHAN_W-1:0]         rsp_red,
   output logic [mscg_pkg::CHAN_W-1:0]         rsp_green,
   output logic [mscg_pkg::CHAN_W-1:0]         rsp_blue,
   output logic [mscg_pkg::STAT_W-1:0]         rsp_status
);

   localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned POS_W   = mscg_pkg::POS_W;
   localparam int unsigned COLOR_W = mscg_pkg::COLOR_W;
   localparam int unsigned CHAN_W  = mscg_pkg::CHAN_W;
   localparam int unsigned ALPHA_W = mscg_pkg::ALPHA_W;
   localparam int unsigned FRAC_W  = mscg_pkg::FRAC_W;
   localparam int unsigned DCNT_W  = mscg_pkg::DCNT_W;
   localparam int unsigned CH_W    = mscg_pkg::CH_W;
   localparam int unsigned ENTRY_W = POS_W + COLOR_W;
   localparam int unsigned PROD_W  = CHAN_W + 1 + ALPHA_W + 1;

   mscg_pkg::action_type        action_ff;
   logic signed [POS_W-1:0]     x_ff;
   logic [COLOR_W-1:0]          color_ff;
   logic [CNT_W-1:0]            count_ff;
   logic signed [POS_W-1:0]     last_pos_ff;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic signed [POS_W-1:0]     p0_ff;
   logic [COLOR_W-1:0]          c0_ff, c1_ff;
   logic [POS_W:0]              rem_ff;
   logic [POS_W-1:0]            den_ff;
   logic [ALPHA_W-1:0]          q_ff;
   logic [DCNT_W-1:0]           dcnt_ff;
   logic [CH_W-1:0]             ch_ff;
   logic [COLOR_W-1:0]          res_rgb_ff;
   mscg_pkg::status_type        res_st_ff;
   logic                        rsp_valid_ff;
   logic [COLOR_W-1:0]          rsp_rgb_ff;
   mscg_pkg::status_type        rsp_st_ff;

   logic                        wr_en;
   logic [ENTRY_W-1:0]          rd_data;
   logic signed [POS_W-1:0]     rd_pos;
   logic [COLOR_W-1:0]          rd_color;
   logic                        order_bad;
   logic                        full;
   logic signed [POS_W:0]       num_wide, den_wide;
   logic [POS_W:0]              den_ext, diff;
   logic                        ge;
   logic [POS_W-1:0]            r_keep;
   logic [CHAN_W-1:0]           c0_chan, c1_chan;
   logic signed [CHAN_W:0]      delta;
   logic signed [PROD_W-1:0]    prod, acc;

   assign rd_pos   = rd_data[ENTRY_W-1:COLOR_W];
   assign rd_color = rd_data[COLOR_W-1:0];

   assign order_bad = (count_ff != '0) && (x_ff <= last_pos_ff);
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign wr_en     = cmd.append && !order_bad && !full;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   mscg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({x_ff, color_ff}),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   // segment setup
   assign num_wide = (POS_W+1)'(x_ff) - (POS_W+1)'(p0_ff);
   assign den_wide = (POS_W+1)'(rd_pos) - (POS_W+1)'(p0_ff);

   // restoring divider step
   assign den_ext = {1'b0, den_ff};
   assign ge      = (rem_ff >= den_ext);
   assign diff    = rem_ff - den_ext;
   assign r_keep  = ge ? diff[POS_W-1:0] : rem_ff[POS_W-1:0];

   // channel blend: c0 + (c1 - c0) * alpha, then drop the fraction
   always_comb begin
      unique case (ch_ff)
         CH_W'(0): begin
            c0_chan = c0_ff[23:16];
            c1_chan = c1_ff[23:16];
         end
         CH_W'(1): begin
            c0_chan = c0_ff[15:8];
            c1_chan = c1_ff[15:8];
         end
         default: begin
            c0_chan = c0_ff[7:0];
            c1_chan = c1_ff[7:0];
         end
      endcase
   end

   assign delta = $signed({1'b0, c1_chan}) - $signed({1'b0, c0_chan});
   assign prod  = PROD_W'(delta) * $signed({1'b0, q_ff});
   assign acc   = prod + $signed(PROD_W'({c0_chan, {FRAC_W{1'b0}}}));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         action_ff <= mscg_pkg::action_type'(req_action);
         x_ff      <= req_position;
         color_ff  <= req_stop_color;
      end
      if (wr_en) begin
         last_pos_ff <= x_ff;
      end
      if (cmd.append) begin
         res_rgb_ff <= '0;
         priority if (order_bad) begin
            res_st_ff <= mscg_pkg::ST_ORDER;
         end else if (full) begin
            res_st_ff <= mscg_pkg::ST_FULL;
         end else begin
            res_st_ff <= mscg_pkg::ST_OK;
         end
      end
      if (cmd.blank) begin
         res_rgb_ff <= '0;
         res_st_ff  <= mscg_pkg::ST_OK;
      end
      if (cmd.few) begin
         res_rgb_ff <= '0;
         res_st_ff  <= mscg_pkg::ST_FEW;
      end
      if (cmd.take_rd) begin
         res_rgb_ff <= rd_color;
         res_st_ff  <= mscg_pkg::ST_OK;
      end
      if (cmd.advance) begin
         p0_ff <= rd_pos;
         c0_ff <= rd_color;
      end
      if (cmd.seg_start) begin
         rem_ff    <= {1'b0, num_wide[POS_W-1:0]};
         den_ff    <= den_wide[POS_W-1:0];
         c1_ff     <= rd_color;
         q_ff      <= '0;
         dcnt_ff   <= '0;
         ch_ff     <= '0;
         res_st_ff <= mscg_pkg::ST_OK;
      end
      if (cmd.div_step) begin
         rem_ff  <= {r_keep, 1'b0};
         q_ff    <= {q_ff[ALPHA_W-2:0], ge};
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
      if (cmd.blend_step) begin
         res_rgb_ff <= {res_rgb_ff[COLOR_W-CHAN_W-1:0], acc[FRAC_W+CHAN_W-1:FRAC_W]};
         ch_ff      <= ch_ff + CH_W'(1);
      end
      if (cmd.emit) begin
         rsp_rgb_ff <= res_rgb_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign stat.action     = action_ff;
   assign stat.count_lt2  = (count_ff < CNT_W'(2));
   assign stat.hit        = (x_ff <= rd_pos);
   assign stat.idx_zero   = (idx_ff == '0);
   assign stat.idx_last   = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
   assign stat.div_last   = (dcnt_ff == DCNT_W'(mscg_pkg::DIV_STEPS - 1));
   assign stat.blend_last = (ch_ff == CH_W'(mscg_pkg::NUM_CHANS - 1));
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_red    = rsp_rgb_ff[23:16];
   assign rsp_green  = rsp_rgb_ff[15:8];
   assign rsp_blue   = rsp_rgb_ff[7:0];
   assign rsp_status = rsp_st_ff;

endmodule

### hw/rtl/multi_stop_color_gradient_top.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_stop_color_gradient_top
// Multi-stop linear color gradient: stop table with interpolated lookup.
// ============================================================================
// Usage:
//   req_ch carries one word per action: clear (0), append stop (1) or
//   lookup (2), with position (signed Q3.12) and stop_color. rsp_ch returns
//   exactly one word per request: red, green, blue and status.
//   One request is in flight at a time; req_ch.ready is high only while the
//   sequencer is idle.
//   Clear, append and unused codes go from decode straight to the hand-off.
//   Lookup: a result clamped at the first or the last stop is taken from the
//   stop scan, and a position inside a segment between two stops also passes
//   the alpha divider and the blender: the stop scan reads one table entry
//   per cycle, the alpha divider resolves one quotient bit per cycle and the
//   blender does one channel per cycle.
//   Reset empties the stop table (count zero) and drops any pending word.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the sequencer holds its next result until the receiver
//   takes the pending one.
// ============================================================================
module multi_stop_color_gradient_top #(
   parameter int unsigned TABLE_DEPTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   mscg_req_if.sink     req_ch,
   mscg_rsp_if.source   rsp_ch
);

   mscg_pkg::cmd_type  cmd;
   mscg_pkg::stat_type stat;

   mscg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mscg_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_ch.action),
      .req_position   (req_ch.position),
      .req_stop_color (req_ch.stop_color),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_red        (rsp_ch.red),
      .rsp_green      (rsp_ch.green),
      .rsp_blue       (rsp_ch.blue),
      .rsp_status     (rsp_ch.status)
   );

endmodule

### tb/tb_multi_stop_color_gradient_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_stop_color_gradient_top
// Self-checking bench for the multi-stop gradient: stop table and lookups.
// Directed words cover empty and one-stop lookups, refused appends, the full
// table, end clamps and the widest segment. Random sequences then build
// tables and look up colors, mixed with stray appends and noise. Every
// accepted request is predicted in a scoreboard and each returned word is
// checked field by field. Sender idling and receiver stalls vary by phase.
// ============================================================================
module tb_multi_stop_color_gradient_top;

   localparam int TABLE_DEPTH = 8;
   localparam int RAND_WORDS  = 1250;

   typedef struct packed {
      logic [mscg_pkg::CHAN_W-1:0] red;
      logic [mscg_pkg::CHAN_W-1:0] green;
      logic [mscg_pkg::CHAN_W-1:0] blue;
      mscg_pkg::status_type        status;
   } color_word_type;

   class color_scoreboard;
      logic signed [mscg_pkg::POS_W-1:0] stop_pos[TABLE_DEPTH];
      logic [mscg_pkg::COLOR_W-1:0]      stop_col[TABLE_DEPTH];
      int unsigned                       stop_cnt;
      color_word_type                    expected_colors[$];
      int mismatch_count, checked_words;
      int clears, appends, refused, lookups, blended, clamped, too_few, unused;

      function logic [mscg_pkg::CHAN_W-1:0] mix(logic [mscg_pkg::CHAN_W-1:0] a,
                                                logic [mscg_pkg::CHAN_W-1:0] b,
                                                longint alpha);
         return mscg_pkg::CHAN_W'((longint'(a) * (65536 - alpha) + longint'(b) * alpha)
                                  >> 16);
      endfunction

      function color_word_type predict_color(mscg_pkg::action_type act,
                                             logic signed [mscg_pkg::POS_W-1:0] x,
                                             logic [mscg_pkg::COLOR_W-1:0] rgb);
         color_word_type w;
         int unsigned seg;
         longint num, den, alpha;
         logic [mscg_pkg::COLOR_W-1:0] c0, c1;
         w = '0;
         w.status = mscg_pkg::ST_OK;
         case (act)
            mscg_pkg::ACT_CLEAR: begin
               clears++;
               stop_cnt = 0;
            end
            mscg_pkg::ACT_APPEND: begin
               appends++;
               if (stop_cnt > 0 && x <= stop_pos[stop_cnt-1]) begin
                  w.status = mscg_pkg::ST_ORDER;
                  refused++;
               end else if (stop_cnt >= TABLE_DEPTH) begin
                  w.status = mscg_pkg::ST_FULL;
                  refused++;
               end else begin
                  stop_pos[stop_cnt] = x;
                  stop_col[stop_cnt] = rgb;
                  stop_cnt++;
               end
            end
            mscg_pkg::ACT_LOOKUP: begin
               lookups++;
               if (stop_cnt < 2) begin
                  w.status = mscg_pkg::ST_FEW;
                  too_few++;
               end else if (x <= stop_pos[0]) begin
                  {w.red, w.green, w.blue} = stop_col[0];
                  clamped++;
               end else if (x > stop_pos[stop_cnt-1]) begin
                  {w.red, w.green, w.blue} = stop_col[stop_cnt-1];
                  clamped++;
               end else begin
                  seg = stop_cnt - 2;
                  for (int unsigned i = 0; i + 1 < stop_cnt; i++) begin
                     if (x > stop_pos[i] && x <= stop_pos[i+1]) begin
                        seg = i;
                        break;
                     end
                  end
                  num = longint'(x) - longint'(stop_pos[seg]);
                  den = longint'(stop_pos[seg+1]) - longint'(stop_pos[seg]);
                  if (den == 0) den = 1;
                  alpha = (num << 16) / den;
                  if (alpha > 65536) alpha = 65536;
                  c0 = stop_col[seg];
                  c1 = stop_col[seg+1];
                  w.red   = mix(c0[23:16], c1[23:16], alpha);
                  w.green = mix(c0[15:8], c1[15:8], alpha);
                  w.blue  = mix(c0[7:0], c1[7:0], alpha);
                  blended++;
               end
            end
            default: unused++;
         endcase
         return w;
      endfunction

      function void note_request(mscg_pkg::action_type act,
                                 logic signed [mscg_pkg::POS_W-1:0] x,
                                 logic [mscg_pkg::COLOR_W-1:0] rgb);
         expected_colors.insert(expected_colors.size(), predict_color(act, x, rgb));
      endfunction

      function void check_color(logic [mscg_pkg::CHAN_W-1:0] r,
                                logic [mscg_pkg::CHAN_W-1:0] g,
                                logic [mscg_pkg::CHAN_W-1:0] b,
                                logic [mscg_pkg::STAT_W-1:0] s);
         color_word_type e;
         checked_words++;
         if (expected_colors.size() == 0) begin
            $error("result word with nothing expected: r=%0d g=%0d b=%0d status=%0d",
                   r, g, b, s);
            mismatch_count++;
            return;
         end
         e = expected_colors.pop_front();
         if (r !== e.red) begin
            $error("red mismatch: expected %0d, actual %0d", e.red, r);
            mismatch_count++;
         end
         if (g !== e.green) begin
            $error("green mismatch: expected %0d, actual %0d", e.green, g);
            mismatch_count++;
         end
         if (b !== e.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", e.blue, b);
            mismatch_count++;
         end
         if (s !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, s);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;
   int   sent_words;
   color_scoreboard sb;

   mscg_req_if req_ch();
   mscg_rsp_if rsp_ch();

   multi_stop_color_gradient_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_color(rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.status);
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function logic signed [mscg_pkg::POS_W-1:0] clamp_pos(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return mscg_pkg::POS_W'(v);
   endfunction

   function logic [mscg_pkg::COLOR_W-1:0] rand_color();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return mscg_pkg::COLOR_W'($urandom);
      endcase
   endfunction

   // lookup positions cluster on stops and segments of the current table
   function logic signed [mscg_pkg::POS_W-1:0] pick_lookup_pos();
      int k;
      int lo, hi;
      if (sb.stop_cnt < 2 || $urandom_range(0, 4) == 0) return mscg_pkg::POS_W'($urandom);
      k = $urandom_range(0, sb.stop_cnt - 1);
      case ($urandom_range(0, 2))
         0: return sb.stop_pos[k];
         1: return clamp_pos(int'(sb.stop_pos[k]) + $urandom_range(0, 6) - 3);
         default: begin
            if (k == sb.stop_cnt - 1) k--;
            lo = sb.stop_pos[k];
            hi = sb.stop_pos[k+1];
            return clamp_pos(lo + int'($urandom_range(0, hi - lo)));
         end
      endcase
   endfunction

   task automatic send_word(mscg_pkg::action_type act,
                            logic signed [mscg_pkg::POS_W-1:0] pos,
                            logic [mscg_pkg::COLOR_W-1:0] rgb);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.position   <= pos;
      req_ch.stop_color <= rgb;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(act, pos, rgb);
      sent_words++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // strictly rising positions, step size drawn from a narrow, mid or wide span
   task automatic load_stops(int n);
      int prev, room, lim, span;
      case ($urandom_range(0, 2))
         0: span = 4;
         1: span = 300;
         default: span = 65535;
      endcase
      prev = -32768 + int'($urandom_range(0, 65535 - (n - 1)));
      send_word(mscg_pkg::ACT_APPEND, mscg_pkg::POS_W'(prev), rand_color());
      for (int k = 1; k < n; k++) begin
         room = (32767 - prev) / (n - k);
         lim  = (room < span) ? room : span;
         prev = prev + int'($urandom_range(1, lim));
         send_word(mscg_pkg::ACT_APPEND, mscg_pkg::POS_W'(prev), rand_color());
      end
   endtask

   task automatic run_sequence();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         send_word(mscg_pkg::ACT_CLEAR, mscg_pkg::POS_W'($urandom), rand_color());
         load_stops($urandom_range(2, TABLE_DEPTH));
         repeat ($urandom_range(2, 12)) begin
            if ($urandom_range(0, 7) == 0)
               send_word(mscg_pkg::ACT_APPEND, pick_lookup_pos(), rand_color());
            else
               send_word(mscg_pkg::ACT_LOOKUP, pick_lookup_pos(), rand_color());
         end
      end else if (kind == 7) begin
         repeat ($urandom_range(4, 10))
            send_word(mscg_pkg::action_type'($urandom_range(0, 3)),
                      mscg_pkg::POS_W'($urandom), rand_color());
      end else if (kind == 8) begin
         send_word(mscg_pkg::ACT_CLEAR, mscg_pkg::POS_W'($urandom), rand_color());
         repeat ($urandom_range(0, 1))
            send_word(mscg_pkg::ACT_APPEND, mscg_pkg::POS_W'($urandom), rand_color());
         repeat (3)
            send_word(mscg_pkg::ACT_LOOKUP, mscg_pkg::POS_W'($urandom), rand_color());
      end else begin
         send_word(mscg_pkg::ACT_CLEAR, mscg_pkg::POS_W'($urandom), rand_color());
         load_stops(TABLE_DEPTH);
         repeat ($urandom_range(1, 4))
            send_word(mscg_pkg::ACT_APPEND, pick_lookup_pos(), rand_color());
         repeat (2) send_word(mscg_pkg::ACT_LOOKUP, pick_lookup_pos(), rand_color());
      end
   endtask

   initial begin
      int directed_end;
      logic signed [mscg_pkg::POS_W-1:0] dir_pos[TABLE_DEPTH];
      logic [mscg_pkg::COLOR_W-1:0]      dir_col[TABLE_DEPTH];
      dir_pos = '{-16'sd20000, -16'sd19999, -16'sd8000, 16'sd0, 16'sd1, 16'sd4096,
                  16'sd20000, 16'sd30000};
      dir_col = '{24'hFFFFFF, 24'h000000, 24'h123456, 24'hA5A5A5,
                  24'h5A5A5A, 24'hFF00FF, 24'h00FF00, 24'h80807F};
      sb = new();
      send_idle_pct = 0;
      stall_pct     = 0;
      sent_words    = 0;
      reset              = 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= mscg_pkg::ACT_NONE;
      req_ch.position   <= '0;
      req_ch.stop_color <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty and single-stop tables, duplicate stop, widest possible segment
      send_word(mscg_pkg::ACT_LOOKUP, 16'sd0, 24'h0);
      send_word(mscg_pkg::ACT_APPEND, -16'sd32768, 24'h000000);
      send_word(mscg_pkg::ACT_LOOKUP, 16'sd0, 24'h0);
      send_word(mscg_pkg::ACT_APPEND, -16'sd32768, 24'hFFFFFF);
      send_word(mscg_pkg::ACT_APPEND, 16'sd32767, 24'hFFFFFF);
      send_word(mscg_pkg::ACT_LOOKUP, -16'sd32768, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, -16'sd32767, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, 16'sd0, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, 16'sd32767, 24'h0);
      send_word(mscg_pkg::ACT_NONE, -16'sd1, 24'hFFFFFF);
      send_word(mscg_pkg::ACT_CLEAR, 16'sd0, 24'h0);
      // full table, adjacent stops, refusals on a full table
      for (int k = 0; k < TABLE_DEPTH; k++)
         send_word(mscg_pkg::ACT_APPEND, dir_pos[k], dir_col[k]);
      send_word(mscg_pkg::ACT_APPEND, 16'sd32767, 24'h0);
      send_word(mscg_pkg::ACT_APPEND, 16'sd100, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, 16'sd32767, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, -16'sd32768, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, -16'sd19999, 24'h0);
      send_word(mscg_pkg::ACT_LOOKUP, 16'sd3000, 24'h0);
      send_word(mscg_pkg::ACT_CLEAR, 16'sd0, 24'h0);
      drain_results();

      directed_end = sent_words;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         while (sent_words < directed_end + (p + 1) * RAND_WORDS / 4) run_sequence();
         drain_results();
      end

      stall_pct = 0;
      repeat (40) @(posedge clock);
      $display("Covered %0d words: %0d clears, %0d appends (%0d refused), %0d unused codes.",
               sb.checked_words, sb.clears, sb.appends, sb.refused, sb.unused);
      $display("Lookups %0d: %0d interpolated, %0d clamped to an end, %0d with too few stops.",
               sb.lookups, sb.blended, sb.clamped, sb.too_few);
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
hw/rtl/mscg_pkg.sv
hw/rtl/mscg_req_if.sv
hw/rtl/mscg_rsp_if.sv
hw/rtl/mscg_ram.sv
hw/rtl/mscg_ctrl.sv
hw/rtl/mscg_dp.sv
hw/rtl/multi_stop_color_gradient_top.sv
tb/tb_multi_stop_color_gradient_top.sv
